// ----- hdl/esrc_pkg.sv -----
// shared types and constants of the expression shift-reduce checker
// no dependencies; imported by every module of the block
package esrc_pkg;

    localparam int unsigned STACK_DEPTH_DEF = 16;
    localparam int unsigned SYM_W           = 8;
    localparam int unsigned DEPTH_OUT_W     = 5;

    localparam logic [SYM_W-1:0] SYM_I      = 8'h69;
    localparam logic [SYM_W-1:0] SYM_D      = 8'h64;
    localparam logic [SYM_W-1:0] SYM_E      = 8'h45;
    localparam logic [SYM_W-1:0] SYM_PLUS   = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_STAR   = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_LPAREN = 8'h28;
    localparam logic [SYM_W-1:0] SYM_RPAREN = 8'h29;

    // one stack move, broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop1;
        logic pop2;
    } esrc_op_t;

    // the three topmost cells, as seen by the control
    typedef struct packed {
        logic [SYM_W-1:0] sym2;
        logic [SYM_W-1:0] sym1;
        logic [SYM_W-1:0] sym0;
    } esrc_top_t;

endpackage

// ----- hdl/esrc_cell.sv -----
// one stack cell: holds a symbol, moves down on push, up on reduce
// depends on esrc_pkg
module esrc_cell
    import esrc_pkg::*;
#(
    parameter bit HEAD = 1'b0
) (
    input  logic             aclk,
    input  esrc_op_t         op,
    input  logic [SYM_W-1:0] prev_sym,
    input  logic [SYM_W-1:0] next_sym,
    input  logic [SYM_W-1:0] next2_sym,
    output logic [SYM_W-1:0] sym
);

    logic [SYM_W-1:0] sym_reg;

    always_ff @(posedge aclk) begin
        if (op.push) begin
            sym_reg <= prev_sym;
        end else if (op.pop1) begin
            sym_reg <= HEAD ? SYM_E : next_sym;
        end else if (op.pop2) begin
            sym_reg <= HEAD ? SYM_E : next2_sym;
        end
    end

    assign sym = sym_reg;

endmodule

// ----- hdl/esrc_ctrl.sv -----
// control: depth counter, overflow flag, rule match and result register
// depends on esrc_pkg
module esrc_ctrl
    import esrc_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_last,
    input  esrc_top_t              top,
    output esrc_op_t               op,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_accept,
    output logic                   m_overflow,
    output logic [DEPTH_OUT_W-1:0] m_final_depth
);

    localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_REDUCE
    } state_t;

    state_t                 state_reg;
    logic [DW-1:0]          depth_reg;
    logic                   ovf_reg;
    logic                   last_reg;
    logic                   m_valid_reg;
    logic                   m_accept_reg;
    logic                   m_overflow_reg;
    logic [DEPTH_OUT_W-1:0] m_final_depth_reg;

    logic                   full;
    logic                   match_id;
    logic                   match_tri;
    logic                   emit;
    logic [DW+DEPTH_OUT_W-1:0] depth_ext;

    assign full = (depth_reg == DW'(STACK_DEPTH));

    assign match_id = (depth_reg >= DW'(2)) && (top.sym1 == SYM_I) && (top.sym0 == SYM_D);

    assign match_tri = (depth_reg >= DW'(3)) &&
        (((top.sym2 == SYM_E) && ((top.sym1 == SYM_PLUS) || (top.sym1 == SYM_STAR)) &&
          (top.sym0 == SYM_E)) ||
         ((top.sym2 == SYM_LPAREN) && (top.sym1 == SYM_E) && (top.sym0 == SYM_RPAREN)));

    // result registers are loaded in this cycle
    assign emit = (state_reg == ST_REDUCE) && !match_id && !match_tri && last_reg &&
                  (!m_valid_reg || m_ready);

    assign depth_ext = {{DEPTH_OUT_W{1'b0}}, depth_reg};

    assign s_ready = (state_reg == ST_IDLE);
    assign op.push = (state_reg == ST_IDLE) && s_valid && !full;
    assign op.pop1 = (state_reg == ST_REDUCE) && match_id;
    assign op.pop2 = (state_reg == ST_REDUCE) && !match_id && match_tri;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            depth_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !emit) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        last_reg <= s_last;
                        if (full) begin
                            ovf_reg <= 1'b1;
                        end else begin
                            depth_reg <= depth_reg + DW'(1);
                        end
                        state_reg <= ST_REDUCE;
                    end
                end
                ST_REDUCE: begin
                    if (match_id) begin
                        depth_reg <= depth_reg - DW'(1);
                    end else if (match_tri) begin
                        depth_reg <= depth_reg - DW'(2);
                    end else if (!last_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (!m_valid_reg || m_ready) begin
                        m_valid_reg       <= 1'b1;
                        m_accept_reg      <= !ovf_reg && (depth_reg == DW'(1)) &&
                                             (top.sym0 == SYM_E);
                        m_overflow_reg    <= ovf_reg;
                        m_final_depth_reg <= depth_ext[DEPTH_OUT_W-1:0];
                        depth_reg         <= '0;
                        ovf_reg           <= 1'b0;
                        state_reg         <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_accept      = m_accept_reg;
    assign m_overflow    = m_overflow_reg;
    assign m_final_depth = m_final_depth_reg;

endmodule

// ----- hdl/expression_shift_reduce_checker_core.sv -----
// top level of the expression shift-reduce checker: control plus a row of stack cells
// depends on esrc_pkg, esrc_cell and esrc_ctrl
//
// Each request carries one byte of an expression string over the grammar
// E -> E+E | E*E | (E) | id. The stack is a row of STACK_DEPTH cells with the
// top in cell 0; a push moves every cell down one place, a reduction moves
// them up one or two places and loads 'E' into the top. An item is first
// shifted, then reduced once per rule that fits, and ends when the control
// finds that no rule fits; it tests the three top cells once per cycle and
// takes no new request until then. A push onto a full stack drops the byte
// and sets a sticky overflow flag that forces reject. The request marked last
// yields one result (accept, overflow, stack depth in 5 bits), after which the
// stack is emptied; it waits in the final cycle while an earlier result is
// still held. No clearing pass is needed after reset.
module expression_shift_reduce_checker_core
    import esrc_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SYM_W-1:0]       s_symbol,
    input  logic                   s_last,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_accept,
    output logic                   m_overflow,
    output logic [DEPTH_OUT_W-1:0] m_final_depth
);

    esrc_op_t         op;
    esrc_top_t        top;
    logic [SYM_W-1:0] cell_sym [STACK_DEPTH];

    assign top.sym0 = cell_sym[0];
    assign top.sym1 = cell_sym[1];
    assign top.sym2 = cell_sym[2];

    esrc_ctrl #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_last        (s_last),
        .top           (top),
        .op            (op),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_accept      (m_accept),
        .m_overflow    (m_overflow),
        .m_final_depth (m_final_depth)
    );

    for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
        logic [SYM_W-1:0] prev_sym;
        logic [SYM_W-1:0] next_sym;
        logic [SYM_W-1:0] next2_sym;

        if (k == 0) begin : g_head
            assign prev_sym = s_symbol;
        end else begin : g_body
            assign prev_sym = cell_sym[k-1];
        end

        if (k + 1 < STACK_DEPTH) begin : g_n1
            assign next_sym = cell_sym[k+1];
        end else begin : g_n1_tail
            assign next_sym = '0;
        end

        if (k + 2 < STACK_DEPTH) begin : g_n2
            assign next2_sym = cell_sym[k+2];
        end else begin : g_n2_tail
            assign next2_sym = '0;
        end

        esrc_cell #(
            .HEAD(k == 0)
        ) u_cell (
            .aclk      (aclk),
            .op        (op),
            .prev_sym  (prev_sym),
            .next_sym  (next_sym),
            .next2_sym (next2_sym),
            .sym       (cell_sym[k])
        );
    end

endmodule

// ----- hdl/esrc_checker.sv -----
// port-level checks of the expression shift-reduce checker, bound to the top level
// depends on esrc_pkg and expression_shift_reduce_checker_core
module esrc_checker
    import esrc_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic [SYM_W-1:0]       s_symbol,
    input logic                   s_last,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic                   m_accept,
    input logic                   m_overflow,
    input logic [DEPTH_OUT_W-1:0] m_final_depth
);

    // waiting request stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=>
            s_valid && $stable({s_symbol, s_last}))
        else $error("request changed while waiting");

    // held result stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=>
            m_valid && $stable({m_accept, m_overflow, m_final_depth}))
        else $error("result changed while stalled");

    // accept only without overflow
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accept |-> !m_overflow)
        else $error("accept with overflow");

    // accept only with a single symbol left
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accept |-> m_final_depth == DEPTH_OUT_W'(1))
        else $error("accept with depth other than one");

    // no result right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind expression_shift_reduce_checker_core esrc_checker u_esrc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_symbol      (s_symbol),
    .s_last        (s_last),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_accept      (m_accept),
    .m_overflow    (m_overflow),
    .m_final_depth (m_final_depth)
);
